// ----- rtl/core/grid_spiral_legalizer_macros.svh -----
// Assertion macros shared by the checker of the spiral legalizer.
`ifndef GRID_SPIRAL_LEGALIZER_MACROS_SVH
`define GRID_SPIRAL_LEGALIZER_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define GSL_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define GSL_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/gsl_pkg.sv -----
// Shared types and constants of the spiral legalizer.
package gsl_pkg;

  localparam int GRID_SIDE_DEF = 64;
  localparam int MAX_CELLS_DEF = 4096;

  localparam int IDW  = 12;        // cell id width
  localparam int EW   = IDW + 1;   // grid entry: valid bit and id
  localparam int PW   = 6;         // position width
  localparam int SZW  = 7;         // cell size width
  localparam int CFGW = 7;         // configuration register width
  localparam int SW   = 11;        // signed width of search coordinates

  localparam logic [CFGW-1:0] GRID_DIM_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_LEGAL = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic REG_GRID_W = 1'b0;
  localparam logic REG_GRID_H = 1'b1;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic swp_clr;
    logic erase_rd;
    logic erase_wr;
    logic cand_first;
    logic cand_next;
    logic fp_start;
    logic fp_step;
    logic fp_wr;
    logic take_cand;
    logic set_fail;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic mod_done;
    logic swp_last;
    logic cand_ok;
    logic cand_last;
    logic fp_empty;
    logic fp_last;
    logic conflict;
  } dp_stat_t;

endpackage

// ----- rtl/core/gsl_ram.sv -----
// Generic single write port RAM with a registered read port.
module gsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gsl_datapath.sv -----
// Datapath of the spiral legalizer: grid memory, sweep, spiral and footprint counters.
module gsl_datapath import gsl_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CFGW-1:0] cfg_data,
  input  logic [1:0]      cmd,
  input  logic [IDW-1:0]  cell_id,
  input  logic [PW-1:0]   pos_x,
  input  logic [PW-1:0]   pos_y,
  input  logic [SZW-1:0]  cell_width,
  input  logic [SZW-1:0]  cell_height,
  input  dp_cmd_t         dcmd,
  output dp_stat_t        stat,
  output logic [PW-1:0]   new_x,
  output logic [PW-1:0]   new_y,
  output logic            found
);

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] SIDE_A = AW'(GRID_SIDE);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
  localparam logic signed [SW-1:0] SIDE_S = SW'(GRID_SIDE);
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);
  localparam logic [IDW-1:0] MOD_SUB = IDW'(MAX_CELLS);

  logic [CFGW-1:0] grid_w;
  logic [CFGW-1:0] grid_h;
  cmd_t            cmd_q;
  logic [IDW-1:0]  id_q;
  logic [PW-1:0]   px_q;
  logic [PW-1:0]   py_q;
  logic [SZW-1:0]  w_q;
  logic [SZW-1:0]  h_q;
  logic [AW-1:0]   swp;
  logic [AW-1:0]   rd_addr_q;
  logic            rd_pend;
  logic signed [SW-1:0] r;
  logic signed [SW-1:0] dx;
  logic signed [SW-1:0] dy;
  logic [SZW-1:0]  fx;
  logic [SZW-1:0]  fy;
  logic signed [SW-1:0] bx;
  logic signed [SW-1:0] by;
  logic [PW-1:0]   res_x;
  logic [PW-1:0]   res_y;
  logic            found_q;

  logic signed [SW-1:0] gw, gh, maxr_m1;
  logic signed [SW-1:0] pxs, pys, ws, hs, fxs, fys;
  logic signed [SW-1:0] cx, cy, rx, ry, wx, wy;
  logic            wr_in;
  logic [AW-1:0]   fp_raddr, fp_waddr;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [EW-1:0]   ram_wdata, ram_rdata;
  logic            match;

  always_comb begin
    gw = (grid_w > CFGW'(GRID_SIDE > 127 ? 127 : GRID_SIDE) && GRID_SIDE <= 127) ?
         SIDE_S : $signed({{(SW-CFGW){1'b0}}, grid_w});
    gh = (grid_h > CFGW'(GRID_SIDE > 127 ? 127 : GRID_SIDE) && GRID_SIDE <= 127) ?
         SIDE_S : $signed({{(SW-CFGW){1'b0}}, grid_h});
    maxr_m1 = ((gw > gh) ? gw : gh) - ONE_S;
    pxs = $signed({{(SW-PW){1'b0}}, px_q});
    pys = $signed({{(SW-PW){1'b0}}, py_q});
    ws  = $signed({{(SW-SZW){1'b0}}, w_q});
    hs  = $signed({{(SW-SZW){1'b0}}, h_q});
    fxs = $signed({{(SW-SZW){1'b0}}, fx});
    fys = $signed({{(SW-SZW){1'b0}}, fy});
    cx  = pxs + dx;
    cy  = pys + dy;
    rx  = cx + fxs;
    ry  = cy + fys;
    wx  = bx + fxs;
    wy  = by + fys;
    wr_in = (wx >= 0) && (wy >= 0) && (wx < gw) && (wy < gh);
    fp_raddr = AW'(ry) * SIDE_A + AW'(rx);
    fp_waddr = AW'(wy) * SIDE_A + AW'(wx);
    match = ram_rdata[IDW] && (ram_rdata[IDW-1:0] == id_q);
  end

  always_comb begin
    stat.cmd       = cmd_q;
    stat.mod_done  = ({20'd0, id_q} < 32'(MAX_CELLS));
    stat.swp_last  = (swp == LAST_A);
    stat.cand_ok   = (cx >= 0) && (cy >= 0) && (cx + ws <= gw) && (cy + hs <= gh);
    stat.cand_last = (r >= maxr_m1) && (dy == r) && (dx == r);
    stat.fp_empty  = (w_q == '0) || (h_q == '0);
    stat.fp_last   = (fx == w_q - SZW'(1)) && (fy == h_q - SZW'(1));
    stat.conflict  = ram_rdata[IDW] && (ram_rdata[IDW-1:0] != id_q);
  end

  always_comb begin
    ram_raddr = dcmd.erase_rd ? swp : fp_raddr;
    ram_we    = 1'b0;
    ram_waddr = fp_waddr;
    ram_wdata = {1'b1, id_q};
    if (dcmd.swp_clr) begin
      ram_we    = 1'b1;
      ram_waddr = swp;
      ram_wdata = '0;
    end else if (dcmd.erase_wr) begin
      ram_we    = rd_pend && match;
      ram_waddr = rd_addr_q;
      ram_wdata = '0;
    end else if (dcmd.fp_wr) begin
      ram_we    = wr_in;
    end
  end

  gsl_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w  <= GRID_DIM_RESET;
      grid_h  <= GRID_DIM_RESET;
      swp     <= '0;
      rd_pend <= 1'b0;
      cmd_q   <= CMD_NONE;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GRID_W) begin
          grid_w <= cfg_data;
        end else begin
          grid_h <= cfg_data;
        end
      end
      rd_pend <= dcmd.erase_rd;
      if (dcmd.load) begin
        swp   <= '0;
        cmd_q <= cmd_t'(cmd);
      end else if (dcmd.swp_clr || dcmd.erase_rd) begin
        swp <= (swp == LAST_A) ? '0 : swp + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.erase_rd) begin
      rd_addr_q <= swp;
    end
    if (dcmd.load) begin
      id_q    <= cell_id;
      px_q    <= pos_x;
      py_q    <= pos_y;
      w_q     <= cell_width;
      h_q     <= cell_height;
      res_x   <= pos_x;
      res_y   <= pos_y;
      bx      <= $signed({{(SW-PW){1'b0}}, pos_x});
      by      <= $signed({{(SW-PW){1'b0}}, pos_y});
      found_q <= (cmd_t'(cmd) != CMD_NONE);
    end
    if (dcmd.mod_step) begin
      id_q <= id_q - MOD_SUB;
    end
    if (dcmd.cand_first) begin
      r  <= '0;
      dx <= '0;
      dy <= '0;
    end else if (dcmd.cand_next) begin
      // Rows strictly inside the square only visit their left and right edge columns.
      if (dx == r) begin
        if (dy == r) begin
          r  <= r + ONE_S;
          dy <= -(r + ONE_S);
          dx <= -(r + ONE_S);
        end else begin
          dy <= dy + ONE_S;
          dx <= -r;
        end
      end else if ((dy == r) || (dy == -r)) begin
        dx <= dx + ONE_S;
      end else begin
        dx <= r;
      end
    end
    if (dcmd.fp_start) begin
      fx <= '0;
      fy <= '0;
    end else if (dcmd.fp_step) begin
      if (fx == w_q - SZW'(1)) begin
        fx <= '0;
        fy <= fy + SZW'(1);
      end else begin
        fx <= fx + SZW'(1);
      end
    end
    if (dcmd.take_cand) begin
      bx    <= cx;
      by    <= cy;
      res_x <= cx[PW-1:0];
      res_y <= cy[PW-1:0];
    end
    if (dcmd.set_fail) begin
      found_q <= 1'b0;
    end
    if (dcmd.out_load) begin
      new_x <= res_x;
      new_y <= res_y;
      found <= found_q;
    end
  end

endmodule

// ----- rtl/core/gsl_ctrl.sv -----
// Controller state machine of the spiral legalizer.
module gsl_ctrl import gsl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);

  typedef enum logic [11:0] {
    S_INIT  = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_MOD   = 12'b000000000100,
    S_CLEAR = 12'b000000001000,
    S_ERASE = 12'b000000010000,
    S_ETAIL = 12'b000000100000,
    S_CAND  = 12'b000001000000,
    S_FRD   = 12'b000010000000,
    S_FCHK  = 12'b000100000000,
    S_WRITE = 12'b001000000000,
    S_DONE  = 12'b010000000000,
    S_SPARE = 12'b100000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    dcmd       = '0;
    case (state)
      S_INIT: begin
        dcmd.swp_clr = 1'b1;
        if (stat.swp_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          dcmd.load  = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (!stat.mod_done) begin
          dcmd.mod_step = 1'b1;
        end else begin
          case (stat.cmd)
            CMD_CLEAR: state_next = S_CLEAR;
            CMD_MARK: begin
              dcmd.fp_start = 1'b1;
              state_next    = S_WRITE;
            end
            CMD_LEGAL: state_next = S_ERASE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        dcmd.swp_clr = 1'b1;
        if (stat.swp_last) state_next = S_DONE;
      end
      S_ERASE: begin
        dcmd.erase_rd = 1'b1;
        dcmd.erase_wr = 1'b1;
        if (stat.swp_last) state_next = S_ETAIL;
      end
      S_ETAIL: begin
        dcmd.erase_wr   = 1'b1;
        dcmd.cand_first = 1'b1;
        state_next      = S_CAND;
      end
      S_CAND: begin
        if (stat.cand_ok) begin
          dcmd.fp_start = 1'b1;
          if (stat.fp_empty) begin
            dcmd.take_cand = 1'b1;
            state_next     = S_WRITE;
          end else begin
            state_next = S_FRD;
          end
        end else if (stat.cand_last) begin
          dcmd.set_fail = 1'b1;
          dcmd.fp_start = 1'b1;
          state_next    = S_WRITE;
        end else begin
          dcmd.cand_next = 1'b1;
        end
      end
      S_FRD: begin
        state_next = S_FCHK;
      end
      S_FCHK: begin
        if (stat.conflict) begin
          if (stat.cand_last) begin
            dcmd.set_fail = 1'b1;
            dcmd.fp_start = 1'b1;
            state_next    = S_WRITE;
          end else begin
            dcmd.cand_next = 1'b1;
            state_next     = S_CAND;
          end
        end else if (stat.fp_last) begin
          dcmd.take_cand = 1'b1;
          dcmd.fp_start  = 1'b1;
          state_next     = S_WRITE;
        end else begin
          dcmd.fp_step = 1'b1;
          state_next   = S_FRD;
        end
      end
      S_WRITE: begin
        if (stat.fp_empty) begin
          state_next = S_DONE;
        end else begin
          dcmd.fp_wr = 1'b1;
          if (stat.fp_last) begin
            state_next = S_DONE;
          end else begin
            dcmd.fp_step = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          dcmd.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dcmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/grid_spiral_legalizer.sv -----
// Top level of the spiral legalizer: one request at a time, results through an output register.
// Clear sweeps the whole grid; mark writes the width*height footprint squares inside the grid.
// Legalize sweeps the grid to erase the id, then tests spiral candidates, reading the footprint
// of a fitting candidate up to a square of another id, then writes the in-grid squares.
// All these steps share the single grid memory port pair.
// After reset a clearing pass over the whole grid runs before the first request.
module grid_spiral_legalizer import gsl_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CFGW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      cmd,
  input  logic [IDW-1:0]  cell_id,
  input  logic [PW-1:0]   pos_x,
  input  logic [PW-1:0]   pos_y,
  input  logic [SZW-1:0]  cell_width,
  input  logic [SZW-1:0]  cell_height,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [PW-1:0]   new_x,
  output logic [PW-1:0]   new_y,
  output logic            found
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  gsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .dcmd      (dcmd)
  );

  gsl_datapath #(
    .GRID_SIDE (GRID_SIDE),
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .cell_id     (cell_id),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .cell_width  (cell_width),
    .cell_height (cell_height),
    .dcmd        (dcmd),
    .stat        (stat),
    .new_x       (new_x),
    .new_y       (new_y),
    .found       (found)
  );

endmodule

// ----- rtl/core/gsl_checker.sv -----
// Port checker of the spiral legalizer and its bind to the top level.
`include "grid_spiral_legalizer_macros.svh"

module gsl_checker import gsl_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [PW-1:0]   new_x,
  input logic [PW-1:0]   new_y,
  input logic            found
);

  // The grid is being cleared right after reset, so no request may enter.
  `GSL_ASSERT_NOW(a_init_busy, clk, rst, $past(rst), in_stall, "request taken during clearing pass")
  // Only one request is in flight: the block turns busy after taking one.
  `GSL_ASSERT_NEXT(a_one_req, clk, rst, in_valid && !in_stall, in_stall, "second request taken")
  // A stalled result stays offered.
  `GSL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  // A stalled result keeps its payload.
  `GSL_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(new_x) && $stable(new_y) && $stable(found), "result changed while stalled")

endmodule

bind grid_spiral_legalizer gsl_checker u_gsl_checker (.*);

// ----- test/grid_spiral_legalizer_checker.sv -----
// Checker of the spiral legalizer: predicts each result from the grid model and compares.
`timescale 1ns / 100ps

module grid_spiral_legalizer_checker import gsl_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CFGW-1:0] cfg_data,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [1:0]      cmd,
  input  logic [IDW-1:0]  cell_id,
  input  logic [PW-1:0]   pos_x,
  input  logic [PW-1:0]   pos_y,
  input  logic [SZW-1:0]  cell_width,
  input  logic [SZW-1:0]  cell_height,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [PW-1:0]   new_x,
  input  logic [PW-1:0]   new_y,
  input  logic            found,
  output int              errors,
  output int              pending
);

  localparam int SIDE = GRID_SIDE_DEF;

  typedef struct packed {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic          ok;
  } placement_t;

  logic [EW-1:0]   occ_map [SIDE*SIDE];
  logic [CFGW-1:0] grid_w_reg;
  logic [CFGW-1:0] grid_h_reg;
  placement_t      placement_q [$];

  function automatic bit spot_free(int x, int y, int w, int h, int gw, int gh,
                                   logic [IDW-1:0] id);
    logic [EW-1:0] e;
    if (x < 0 || y < 0 || x + w > gw || y + h > gh) return 1'b0;
    for (int dy = 0; dy < h; dy++) begin
      for (int dx = 0; dx < w; dx++) begin
        e = occ_map[(y + dy) * SIDE + x + dx];
        if (e[EW-1] && e[IDW-1:0] != id) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void paint(int x, int y, int w, int h, int gw, int gh,
                                logic [IDW-1:0] id);
    for (int dy = 0; dy < h; dy++) begin
      for (int dx = 0; dx < w; dx++) begin
        if (x + dx < gw && y + dy < gh && x + dx >= 0 && y + dy >= 0)
          occ_map[(y + dy) * SIDE + x + dx] = {1'b1, id};
      end
    end
  endfunction

  function automatic placement_t place_cell(logic [1:0] op, logic [IDW-1:0] id,
                                            int px, int py, int w, int h);
    placement_t p;
    int gw, gh, maxr;
    bit hit;
    gw = (grid_w_reg > SIDE) ? SIDE : int'(grid_w_reg);
    gh = (grid_h_reg > SIDE) ? SIDE : int'(grid_h_reg);
    p.x = PW'(px);
    p.y = PW'(py);
    p.ok = 1'b1;
    case (cmd_t'(op))
      CMD_CLEAR: begin
        foreach (occ_map[i]) occ_map[i] = '0;
      end
      CMD_MARK: begin
        paint(px, py, w, h, gw, gh, id);
      end
      CMD_LEGAL: begin
        foreach (occ_map[i])
          if (occ_map[i][EW-1] && occ_map[i][IDW-1:0] == id) occ_map[i] = '0;
        maxr = (gw > gh) ? gw : gh;
        hit = spot_free(px, py, w, h, gw, gh, id);
        // Walk square rings outward; only ring squares are candidates.
        for (int r = 1; r < maxr && !hit; r++) begin
          for (int dy = -r; dy <= r && !hit; dy++) begin
            for (int dx = -r; dx <= r && !hit; dx++) begin
              if ((dx == r || dx == -r || dy == r || dy == -r) &&
                  spot_free(px + dx, py + dy, w, h, gw, gh, id)) begin
                hit = 1'b1;
                p.x = PW'(px + dx);
                p.y = PW'(py + dy);
              end
            end
          end
        end
        p.ok = hit;
        paint(int'(p.x), int'(p.y), w, h, gw, gh, id);
      end
      default: begin
        p.ok = 1'b0;
      end
    endcase
    return p;
  endfunction

  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      foreach (occ_map[i]) occ_map[i] = '0;
      grid_w_reg = GRID_DIM_RESET;
      grid_h_reg = GRID_DIM_RESET;
      placement_q.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (placement_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result x=%0d y=%0d found=%0b",
                                     new_x, new_y, found);
        end else begin
          want = placement_q.pop_front();
          if (new_x !== want.x || new_y !== want.y || found !== want.ok) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected x=%0d y=%0d found=%0b, got x=%0d y=%0d found=%0b",
                       want.x, want.y, want.ok, new_x, new_y, found);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_GRID_W) grid_w_reg = cfg_data;
        else grid_h_reg = cfg_data;
      end
      if (in_valid && !in_stall)
        placement_q = {placement_q, place_cell(cmd, cell_id, pos_x, pos_y,
                                               cell_width, cell_height)};
    end
    pending = placement_q.size();
  end

endmodule

// ----- test/grid_spiral_legalizer_test.sv -----
// Top of the spiral legalizer testbench: clock, reset, requests and verdict.
`timescale 1ns / 100ps

module grid_spiral_legalizer_test import gsl_pkg::*;;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic            cfg_index = REG_GRID_W;
  logic [CFGW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      cmd = CMD_CLEAR;
  logic [IDW-1:0]  cell_id = '0;
  logic [PW-1:0]   pos_x = '0;
  logic [PW-1:0]   pos_y = '0;
  logic [SZW-1:0]  cell_width = '0;
  logic [SZW-1:0]  cell_height = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [PW-1:0]   new_x;
  logic [PW-1:0]   new_y;
  logic            found;
  int              errors;
  int              pending;

  int tx_idle = 0;
  int rx_idle = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  always #2 clk = ~clk;

  grid_spiral_legalizer dut (.*);
  grid_spiral_legalizer_checker checker_inst (.*);

  // Receiver stall, with a single long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 30000;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  task automatic send_request(logic [1:0] op, logic [IDW-1:0] id, int x, int y,
                              int w, int h);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd <= op;
    cell_id <= id;
    pos_x <= PW'(x);
    pos_y <= PW'(y);
    cell_width <= SZW'(w);
    cell_height <= SZW'(h);
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_grid(int gw, int gh);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_W;
    cfg_data <= CFGW'(gw);
    @(posedge clk);
    cfg_index <= REG_GRID_H;
    cfg_data <= CFGW'(gh);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [IDW-1:0] ids [6];
    int gw [8];
    int gh [8];
    int roll, sz_w, sz_h;
    logic [IDW-1:0] pick;
    gw = '{64, 8, 1, 0, 100, 12, 5, 127};
    gh = '{64, 8, 1, 5, 3, 6, 127, 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests on the full grid.
    tx_idle = 27;
    rx_idle = 63;
    send_request(CMD_CLEAR, 12'd0, 0, 0, 1, 1);
    send_request(CMD_MARK, 12'd4095, 63, 63, 64, 64);
    send_request(CMD_MARK, 12'd0, 0, 0, 1, 1);
    send_request(CMD_MARK, 12'd7, 0, 0, 2, 2);
    send_request(CMD_LEGAL, 12'd0, 0, 0, 1, 1);
    send_request(CMD_LEGAL, 12'd4095, 63, 63, 1, 1);
    send_request(CMD_LEGAL, 12'd9, 62, 62, 0, 3);
    send_request(CMD_NONE, 12'hAAA, 21, 42, 127, 127);
    send_request(CMD_LEGAL, 12'd5, 0, 0, 64, 64);
    send_request(CMD_LEGAL, 12'd6, 10, 10, 127, 2);
    send_request(CMD_MARK, 12'h555, 42, 21, 3, 100);
    send_request(CMD_LEGAL, 12'd7, 1, 1, 2, 2);
    send_request(CMD_CLEAR, 12'hFFF, 63, 63, 127, 127);
    send_request(CMD_LEGAL, 12'd3, 32, 32, 4, 4);

    for (int k = 1; k < 8; k++) begin
      write_grid(gw[k], gh[k]);
      if (k < 3) begin
        tx_idle = 27;
        rx_idle = 63;
      end else if (k < 6) begin
        tx_idle = 63;
        rx_idle = 27;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      // Long receiver hold-off while requests keep coming, to back up the block.
      if (k == 2) hold_req = 1'b1;
      foreach (ids[i]) ids[i] = IDW'($urandom);
      for (int n = 0; n < 18; n++) begin
        roll = $urandom_range(99);
        pick = ($urandom_range(9) == 0) ? IDW'($urandom) : ids[$urandom_range(5)];
        if ($urandom_range(15) == 0) begin
          sz_w = $urandom_range(127);
          sz_h = $urandom_range(127);
        end else begin
          sz_w = $urandom_range(4);
          sz_h = $urandom_range(4);
        end
        if (roll < 5)
          send_request(CMD_CLEAR, IDW'($urandom), $urandom, $urandom, sz_w, sz_h);
        else if (roll < 8)
          send_request(CMD_NONE, IDW'($urandom), $urandom, $urandom, sz_w, sz_h);
        else if (roll < 45)
          send_request(CMD_MARK, pick, $urandom_range(13), $urandom_range(13), sz_w, sz_h);
        else
          send_request(CMD_LEGAL, pick, ($urandom_range(3) == 0) ? $urandom : $urandom_range(13),
                       $urandom_range(13), sz_w, sz_h);
      end
    end
    write_grid(64, 64);
    send_request(CMD_LEGAL, ids[0], 63, 0, 1, 1);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
